// ===== src/sic_pkg.sv =====
// shared types, codes and constants of the step inflection counter
package sic_pkg;

    localparam int unsigned WINDOW_DEFAULT = 32;

    localparam int unsigned RAW_W      = 14;
    localparam int unsigned AXIS_W     = 18;
    localparam int unsigned FIELD_W    = 18;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned FLOOR_W    = 16;
    localparam int unsigned LIMIT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;

    // sum of squares is below 2^35, root comes out of 18 digit steps
    localparam int unsigned SUMSQ_W    = 36;
    localparam int unsigned ROOT_STEPS = 18;
    localparam int unsigned AXES       = 3;
    // total update, then reciprocal multiply of the window total
    localparam int unsigned DIV_CYCLES = 2;
    // read, difference and product stages drained after the last walk read
    localparam int unsigned FLUSH_CYCLES = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CURVATURE_FLOOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_LIMIT  = CFG_IDX_W'(1);

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(10);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_UPDATE,
        ST_WALK,
        ST_FLUSH,
        ST_OUTPUT
    } sic_state_t;

    typedef struct packed {
        logic       capture;
        logic       square;
        logic [1:0] axis;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       update;
        logic       walk_rd;
        logic       load_out;
    } sic_cmd_t;

    typedef struct packed {
        logic window_last;
    } sic_status_t;

endpackage

// ===== src/step_inflection_counter_core.sv =====
// top level of the step inflection counter
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | s_valid / s_ready   | s_x_raw, s_y_raw, s_z_raw
//  result   | m_valid / m_ready   | m_magnitude, m_filtered, m_window_done,
//           |                     | m_crossing_count
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a request runs from acceptance to the next acceptance through the accept step,
// 3 squaring steps, the 18-step root loop, a reciprocal divide of the window
// total, the memory update and the output load, where the result is registered
// a request closing a window adds a read walk of the filtered memory through
// the difference and product stages
// a new request is taken while the previous result still waits in the output register
// the result stage holds while m_ready is low; config is always ready
// aresetn is synchronous; the windows read as zero until first written
module step_inflection_counter_core #(
    parameter int unsigned WINDOW = sic_pkg::WINDOW_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sic_pkg::RAW_W-1:0]  s_x_raw,
    input  logic signed [sic_pkg::RAW_W-1:0]  s_y_raw,
    input  logic signed [sic_pkg::RAW_W-1:0]  s_z_raw,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sic_pkg::FIELD_W-1:0]       m_magnitude,
    output logic [sic_pkg::FIELD_W-1:0]       m_filtered,
    output logic                              m_window_done,
    output logic [sic_pkg::COUNT_W-1:0]       m_crossing_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sic_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sic_pkg::*;

    localparam int unsigned TOTAL_W = FIELD_W + $clog2(WINDOW);

    sic_cmd_t    cmd;
    sic_status_t status;

    assign cfg_ready = 1'b1;

    sic_ctrl #(
        .WINDOW (WINDOW),
        .TOTAL_W(TOTAL_W)
    ) u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    sic_datapath #(
        .WINDOW (WINDOW),
        .TOTAL_W(TOTAL_W)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_x_raw         (s_x_raw),
        .s_y_raw         (s_y_raw),
        .s_z_raw         (s_z_raw),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_magnitude     (m_magnitude),
        .m_filtered      (m_filtered),
        .m_window_done   (m_window_done),
        .m_crossing_count(m_crossing_count)
    );

endmodule

// ===== src/sic_ctrl.sv =====
// sequencer for the step inflection counter
module sic_ctrl #(
    parameter int unsigned WINDOW = sic_pkg::WINDOW_DEFAULT,
    parameter int unsigned TOTAL_W = 23
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sic_pkg::sic_status_t status,
    output sic_pkg::sic_cmd_t   cmd
);
    import sic_pkg::*;

    localparam int unsigned CNT_W = $clog2(WINDOW + TOTAL_W + 2);

    sic_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SQUARE;
            ST_SQUARE: if (cnt_reg == CNT_W'(AXES - 1)) state_next = ST_ROOT;
            ST_ROOT:   if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) state_next = ST_DIVIDE;
            ST_DIVIDE: if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) state_next = ST_UPDATE;
            ST_UPDATE: state_next = status.window_last ? ST_WALK : ST_OUTPUT;
            ST_WALK:   if (cnt_reg == CNT_W'(WINDOW - 1)) state_next = ST_FLUSH;
            ST_FLUSH:  if (cnt_reg == CNT_W'(FLUSH_CYCLES - 1)) state_next = ST_OUTPUT;
            ST_OUTPUT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.capture = s_valid;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                cmd.axis = cnt_reg[1:0];
            end
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_DIVIDE: begin
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
            end
            ST_UPDATE: cmd.update = 1'b1;
            ST_WALK:   cmd.walk_rd = 1'b1;
            ST_FLUSH:  cmd.walk_rd = 1'b0;
            ST_OUTPUT: cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    assign m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_walk_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_WALK) |-> $past(state_reg == ST_UPDATE))
        else $error("walk entered without an update");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUTPUT && m_valid_reg && !m_ready) |=> state_reg == ST_OUTPUT)
        else $error("result dropped while output stalled");
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUTPUT))
        else $error("result shown outside output step");
    a_root_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> cnt_reg < CNT_W'(ROOT_STEPS))
        else $error("root iteration overrun");

endmodule

// ===== src/sic_datapath.sv =====
// scaling, square root, moving average, window memories and crossing walk
module sic_datapath #(
    parameter int unsigned WINDOW = sic_pkg::WINDOW_DEFAULT,
    parameter int unsigned TOTAL_W = 23
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sic_pkg::sic_cmd_t                     cmd,
    output sic_pkg::sic_status_t                  status,
    input  logic signed [sic_pkg::RAW_W-1:0]      s_x_raw,
    input  logic signed [sic_pkg::RAW_W-1:0]      s_y_raw,
    input  logic signed [sic_pkg::RAW_W-1:0]      s_z_raw,
    input  logic                                  cfg_valid,
    input  logic [sic_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sic_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic [sic_pkg::FIELD_W-1:0]           m_magnitude,
    output logic [sic_pkg::FIELD_W-1:0]           m_filtered,
    output logic                                  m_window_done,
    output logic [sic_pkg::COUNT_W-1:0]           m_crossing_count
);
    import sic_pkg::*;

    localparam int unsigned PTR_W  = $clog2(WINDOW);
    localparam int unsigned DIFF_W = FIELD_W + 3;
    localparam int unsigned PROD_W = 2 * DIFF_W;

    // floor(total / WINDOW) as (total * ceil(2^DIV_SHIFT / WINDOW)) >> DIV_SHIFT,
    // exact for every total below 2^TOTAL_W
    localparam int unsigned DIV_SHIFT = TOTAL_W + $clog2(WINDOW);
    localparam int unsigned RECIP_W   = TOTAL_W + 2;
    localparam int unsigned DIVP_W    = TOTAL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    function automatic logic signed [AXIS_W-1:0] scale_axis(input logic signed [RAW_W-1:0] raw);
        logic signed [28:0] prod;
        prod = 29'(raw) * 29'sd9810;
        // truncate toward zero on the shift
        if (prod < 0) begin
            prod = prod + 29'sd1023;
        end
        return AXIS_W'(prod >>> 10);
    endfunction

    // configuration
    logic [FLOOR_W-1:0] floor_reg;
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_CURVATURE_FLOOR) floor_reg <= cfg_data[FLOOR_W-1:0];
            if (cfg_index == CFG_CROSSING_LIMIT)  limit_reg <= cfg_data[LIMIT_W-1:0];
        end
    end

    // scaled axes and sum of squares
    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [AXIS_W-1:0] axis_sel;
    logic [AXIS_W-2:0]        axis_abs;
    logic [SUMSQ_W-1:0]       sq_w;

    always_comb begin
        unique case (cmd.axis)
            2'd0:    axis_sel = ax_reg;
            2'd1:    axis_sel = ay_reg;
            default: axis_sel = az_reg;
        endcase
    end
    assign axis_abs = axis_sel[AXIS_W-1] ? (AXIS_W-1)'(-axis_sel) : axis_sel[AXIS_W-2:0];
    assign sq_w     = SUMSQ_W'(axis_abs * axis_abs);

    // digit-by-digit square root, sum of squares accumulates into rem_reg
    logic [SUMSQ_W-1:0] rem_reg, root_reg, bit_reg, trial_w;
    assign trial_w = root_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ax_reg   <= scale_axis(s_x_raw);
            ay_reg   <= scale_axis(s_y_raw);
            az_reg   <= scale_axis(s_z_raw);
            rem_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= SUMSQ_W'(1) << (2 * (ROOT_STEPS - 1));
        end else if (cmd.square) begin
            rem_reg <= rem_reg + sq_w;
        end else if (cmd.root_step) begin
            if (rem_reg >= trial_w) begin
                rem_reg  <= rem_reg - trial_w;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // window memories, both written at the same slot
    logic [FIELD_W-1:0] mag_mem  [WINDOW];
    logic [FIELD_W-1:0] filt_mem [WINDOW];
    logic [WINDOW-1:0]  valid_reg;
    logic [PTR_W-1:0]   ptr_reg, waddr_reg;
    logic [FIELD_W-1:0] old_rd_reg, f_rd_reg;
    logic               old_vld_reg;
    logic [FIELD_W-1:0] old_w;
    logic               last_slot;
    logic [FIELD_W-1:0] quo_reg;

    assign last_slot          = (ptr_reg == PTR_W'(WINDOW - 1));
    assign status.window_last = last_slot;
    assign old_w              = old_vld_reg ? old_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            old_rd_reg <= mag_mem[ptr_reg];
        end
        if (cmd.walk_rd) begin
            f_rd_reg <= filt_mem[waddr_reg];
        end
        if (cmd.update) begin
            mag_mem[ptr_reg]  <= root_reg[FIELD_W-1:0];
            filt_mem[ptr_reg] <= quo_reg;
        end
    end

    // running total and reciprocal multiply by the window size
    logic [TOTAL_W-1:0] total_reg, total_w;
    logic [DIVP_W-1:0]  quo_prod_w;
    logic               done_reg;

    assign total_w    = total_reg - TOTAL_W'(old_w) + TOTAL_W'(root_reg[FIELD_W-1:0]);
    assign quo_prod_w = DIVP_W'(total_reg) * DIVP_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            quo_reg <= quo_prod_w[DIV_SHIFT +: FIELD_W];
        end
    end

    // crossing walk: read, second difference, product, compare
    logic [FIELD_W-1:0]       fa_reg, fb_reg;
    logic [1:0]               fill_reg;
    logic                     rd_vld_reg, d_vld_reg, dprev_have_reg, p_vld_reg;
    logic signed [DIFF_W-1:0] d_w, d_reg, dprev_reg;
    logic [DIFF_W-1:0]        dmag_w;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W:0]   chk_w;
    logic [COUNT_W-1:0]       count_reg;

    assign d_w = $signed({3'b000, fa_reg}) - $signed({2'b00, fb_reg, 1'b0})
               + $signed({3'b000, f_rd_reg});
    assign dmag_w = d_w[DIFF_W-1] ? DIFF_W'(-d_w) : d_w;
    assign chk_w  = (PROD_W + 1)'(p_reg) + $signed({{(PROD_W + 1 - LIMIT_W){1'b0}}, limit_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            ptr_reg        <= '0;
            waddr_reg      <= '0;
            total_reg      <= '0;
            old_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            fill_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            d_vld_reg      <= 1'b0;
            dprev_have_reg <= 1'b0;
            p_vld_reg      <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (cmd.capture) begin
                old_vld_reg <= valid_reg[ptr_reg];
            end
            if (cmd.div_init) begin
                total_reg <= total_w;
            end
            rd_vld_reg <= cmd.walk_rd;
            if (cmd.walk_rd) begin
                waddr_reg <= waddr_reg + PTR_W'(1);
            end
            if (cmd.update) begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg        <= last_slot ? '0 : ptr_reg + PTR_W'(1);
                done_reg       <= last_slot;
                waddr_reg      <= '0;
                fill_reg       <= '0;
                d_vld_reg      <= 1'b0;
                dprev_have_reg <= 1'b0;
                p_vld_reg      <= 1'b0;
                count_reg      <= '0;
            end else begin
                d_vld_reg <= rd_vld_reg && (fill_reg == 2'd2);
                if (rd_vld_reg && fill_reg != 2'd2) begin
                    fill_reg <= fill_reg + 2'd1;
                end
                p_vld_reg <= d_vld_reg && dprev_have_reg;
                if (d_vld_reg) begin
                    dprev_have_reg <= 1'b1;
                end
                if (p_vld_reg && chk_w[PROD_W] && count_reg != '1) begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            fa_reg <= fb_reg;
            fb_reg <= f_rd_reg;
            // small curvature is flattened to zero
            d_reg  <= (dmag_w < DIFF_W'(floor_reg)) ? '0 : d_w;
        end
        if (d_vld_reg) begin
            dprev_reg <= d_reg;
            p_reg     <= PROD_W'(dprev_reg) * PROD_W'(d_reg);
        end
        if (cmd.load_out) begin
            m_magnitude      <= root_reg[FIELD_W-1:0];
            m_filtered       <= quo_reg;
            m_window_done    <= done_reg;
            m_crossing_count <= count_reg;
        end
    end

endmodule

// ===== test/tb_step_inflection_counter_core.sv =====
// self-checking testbench for the step inflection counter core
module tb_step_inflection_counter_core;
    import sic_pkg::*;

    localparam int WIN = 32;
    // an index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(15);

    typedef struct {
        logic [FIELD_W-1:0] magnitude;
        logic [FIELD_W-1:0] filtered;
        logic               window_done;
        logic [COUNT_W-1:0] crossing_count;
    } step_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [RAW_W-1:0] s_x_raw = '0, s_y_raw = '0, s_z_raw = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [FIELD_W-1:0] m_magnitude, m_filtered;
    logic m_window_done;
    logic [COUNT_W-1:0] m_crossing_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    step_inflection_counter_core #(.WINDOW(WIN)) dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    longint unsigned floor_reg, limit_reg;
    longint unsigned mag_win[WIN];
    longint unsigned filt_win[WIN];
    int unsigned items_in_window;

    step_result_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int windows_seen = 0;
    bit quiet = 1'b0;
    bit stall_on = 1'b1;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    function automatic longint scale_axis(input logic signed [RAW_W-1:0] raw);
        longint v;
        v = raw;
        return (v * 9810) / 1024;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        r = 0;
        for (int b = 17; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r |= 64'd1 << b;
        return r;
    endfunction

    function automatic int unsigned count_inflections();
        longint d[WIN];
        longint m;
        int unsigned found;
        found = 0;
        for (int i = 1; i < WIN - 1; i++) begin
            d[i-1] = longint'(filt_win[i-1]) - 2 * longint'(filt_win[i])
                     + longint'(filt_win[i+1]);
            m = d[i-1] < 0 ? -d[i-1] : d[i-1];
            if (m < longint'(floor_reg)) d[i-1] = 0;
        end
        for (int i = 1; i < WIN - 2; i++)
            if (d[i-1] * d[i] < -longint'(limit_reg) && found < 255) found++;
        return found;
    endfunction

    function automatic void predict_step(input logic signed [RAW_W-1:0] x, y, z);
        longint ax, ay, az;
        longint unsigned total;
        step_result_t r;
        ax = scale_axis(x);
        ay = scale_axis(y);
        az = scale_axis(z);
        r.magnitude = FIELD_W'(floor_root(ax * ax + ay * ay + az * az));
        total = 0;
        for (int i = 0; i < WIN - 1; i++) mag_win[i] = mag_win[i+1];
        mag_win[WIN-1] = r.magnitude;
        foreach (mag_win[i]) total += mag_win[i];
        r.filtered = FIELD_W'(total / WIN);
        for (int i = 0; i < WIN - 1; i++) filt_win[i] = filt_win[i+1];
        filt_win[WIN-1] = r.filtered;
        items_in_window++;
        r.window_done = 1'b0;
        r.crossing_count = '0;
        if (items_in_window >= WIN) begin
            items_in_window = 0;
            r.window_done = 1'b1;
            r.crossing_count = COUNT_W'(count_inflections());
        end
        expected_q.push_back(r);
    endfunction

    // valid stays up after a request unless a gap follows or the stream stops
    task automatic send_sample(input logic signed [RAW_W-1:0] x, y, z);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_x_raw <= x;
        s_y_raw <= y;
        s_z_raw <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_step(x, y, z);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_CURVATURE_FLOOR) floor_reg = val[FLOOR_W-1:0];
        else if (idx == CFG_CROSSING_LIMIT) limit_reg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [RAW_W-1:0] rand_raw();
        return RAW_W'($urandom);
    endfunction

    // result checker with random back-pressure
    always @(posedge aclk) begin
        step_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result %0d", results_seen);
                errors++;
            end else begin
                w = expected_q.pop_front();
                if (m_magnitude !== w.magnitude) report("magnitude", m_magnitude, w.magnitude);
                if (m_filtered !== w.filtered) report("filtered", m_filtered, w.filtered);
                if (m_window_done !== w.window_done)
                    report("window_done", m_window_done, w.window_done);
                if (m_crossing_count !== w.crossing_count)
                    report("crossing_count", m_crossing_count, w.crossing_count);
                if (w.window_done) windows_seen++;
            end
            results_seen++;
        end
    end

    int stall_left = 0;
    always @(negedge aclk) begin
        if (quiet || !stall_on) m_ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    task automatic test_extremes();
        logic signed [RAW_W-1:0] lo, hi;
        lo = 14'sh2000;
        hi = 14'sd8191;
        send_sample(0, 0, 0);
        send_sample(hi, hi, hi);
        send_sample(lo, lo, lo);
        send_sample(lo, 0, hi);
        send_sample(hi, lo, 0);
        send_sample(1, -1, 0);
        send_sample(-1, -1, -1);
        send_sample(14'sd1024, 0, 0);
        send_sample(0, -14'sd1024, 0);
        send_sample(0, 0, 14'sd4096);
        // rest of the first window, early zeros included
        for (int i = 0; i < WIN - 10; i++) send_sample(rand_raw(), rand_raw(), rand_raw());
    endtask

    // a bouncing waveform that makes curvature sign changes
    task automatic run_windows(input int n, input int amp);
        int ph;
        for (int i = 0; i < n * WIN; i++) begin
            ph = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                send_sample(rand_raw(), rand_raw(), rand_raw());
            else
                send_sample(RAW_W'(((i % 4) < 2 ? amp : -amp) + $urandom_range(0, 60) - 30),
                            RAW_W'($urandom_range(0, 400) - 200),
                            RAW_W'(1024 + ((i % 6) * amp) / 3 + ph));
        end
    endtask

    task automatic test_default_thresholds();
        run_windows(3, 3000);
    endtask

    task automatic test_zero_thresholds();
        write_reg(CFG_CURVATURE_FLOOR, 0);
        write_reg(CFG_CROSSING_LIMIT, 0);
        run_windows(2, 2000);
    endtask

    task automatic test_max_thresholds();
        write_reg(CFG_CURVATURE_FLOOR, 32'hFFFF_FFFF);
        write_reg(CFG_CROSSING_LIMIT, 32'hFFFF_FFFF);
        run_windows(1, 8000);
        write_reg(CFG_UNMAPPED, 32'h1234_5678);
        run_windows(1, 500);
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_CURVATURE_FLOOR, $urandom_range(0, 300));
            write_reg(CFG_CROSSING_LIMIT, $urandom_range(0, 200000));
            run_windows(1, $urandom_range(100, 8000));
        end
        quiet = 1'b1;
        run_windows(2, 4000);
    endtask

    initial begin
        floor_reg = FLOOR_RESET;
        limit_reg = LIMIT_RESET;
        foreach (mag_win[i]) begin
            mag_win[i] = 0;
            filt_win[i] = 0;
        end
        items_in_window = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_default_thresholds();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_settings();
        drain();
        repeat (100) @(posedge aclk);
        $display("checked %0d results, %0d of them closing a window", results_seen,
                 windows_seen);
        $display("thresholds covered default, zero, full scale and random values");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sic_pkg.sv
src/sic_ctrl.sv
src/sic_datapath.sv
src/step_inflection_counter_core.sv
test/tb_step_inflection_counter_core.sv
